@@ src/grid_maze_carver_core_defines.svh @@
// Assertion macros for the maze carver core.
`ifndef GRID_MAZE_CARVER_CORE_DEFINES_SVH
`define GRID_MAZE_CARVER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define GMC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("gmc assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define GMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gmc assertion failed");
`else
`define GMC_ASSERT(label, clk, rst, prop)
`define GMC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ src/gmc_pkg.sv @@
// Constants and helper functions for the maze carver core.
`default_nettype none
package gmc_pkg;

   localparam int CSR_IW = 3;
   localparam int CSR_DW = 17;

   localparam logic [CSR_IW-1:0] REG_ROWS      = 3'd0;
   localparam logic [CSR_IW-1:0] REG_COLS      = 3'd1;
   localparam logic [CSR_IW-1:0] REG_START_ROW = 3'd2;
   localparam logic [CSR_IW-1:0] REG_START_COL = 3'd3;
   localparam logic [CSR_IW-1:0] REG_LOOPS_EN  = 3'd4;
   localparam logic [CSR_IW-1:0] REG_THRESHOLD = 3'd5;

   localparam logic [6:0]  ROWS_RESET      = 7'd16;
   localparam logic [6:0]  COLS_RESET      = 7'd16;
   localparam logic [16:0] THRESHOLD_RESET = 17'd9830;

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_CARVE = 2'd1;
   localparam logic [1:0] PH_LOOP  = 2'd2;
   localparam logic [1:0] PH_DONE  = 2'd3;

   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_RIGHT = 2'd3;

   // x mod 3 by folding: 2^16, 2^8, 2^4 and 2^2 are all 1 mod 3
   function automatic logic [1:0] gmc_mod3(input logic [31:0] x);
      logic [16:0] a;
      logic [9:0]  b;
      logic [6:0]  c;
      logic [4:0]  d;
      logic [3:0]  e;
      a = {1'b0, x[31:16]} + {1'b0, x[15:0]};
      b = {1'b0, a[16:8]} + {2'b0, a[7:0]};
      c = {1'b0, b[9:4]} + {3'b0, b[3:0]};
      d = {2'b0, c[6:4]} + {1'b0, c[3:0]};
      e = {1'b0, d[4:2]} + {2'b0, d[1:0]};
      if (e >= 4'd9) begin
         e = e - 4'd9;
      end else if (e >= 4'd6) begin
         e = e - 4'd6;
      end else if (e >= 4'd3) begin
         e = e - 4'd3;
      end
      return e[1:0];
   endfunction

   // direction of the k-th set bit of the candidate mask, lowest bit first
   function automatic logic [1:0] gmc_pick(input logic [3:0] mask, input logic [1:0] k);
      logic [1:0] seen;
      logic [1:0] dir;
      seen = 2'd0;
      dir  = DIR_UP;
      for (int i = 0; i < 4; i++) begin
         if (mask[i]) begin
            if (seen == k) begin
               dir = 2'(i);
            end
            seen = seen + 2'd1;
         end
      end
      return dir;
   endfunction

endpackage
`default_nettype wire

@@ src/grid_maze_carver_core.sv @@
// Maze carver core: depth-first backtracker over a visited map and a cell stack in RAM.
// Carve transfer: idle, neighbour read, carve and emit, then a stack reload state on a pop
//   that leaves cells stacked; two-port visited-map read of four neighbours, stack reload.
// Loop transfer: bit-serial divide of the scan index by the column count, then emit.
// Idle/done transfer: one response. Restart: sweep of all 2^(log2 rows + log2 cols) map entries
//   (4096 at 64x64), then the start-cell response. Reset (synchronous) runs the same sweep.
`default_nettype none
`include "grid_maze_carver_core_defines.svh"
module grid_maze_carver_core #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_restart,
   input  wire logic [31:0]                 req_rnd,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic                             rsp_carve_valid,
   output logic [1:0]                       rsp_carve_dir,
   output logic                             rsp_down_also,
   output logic [5:0]                       rsp_cell_row,
   output logic [5:0]                       rsp_cell_col,
   output logic [1:0]                       rsp_phase_now,
   input  wire logic                        csr_wr_en,
   input  wire logic [gmc_pkg::CSR_IW-1:0]  csr_index,
   input  wire logic [gmc_pkg::CSR_DW-1:0]  csr_wdata
);
   import gmc_pkg::*;

   localparam int RW    = $clog2(MAX_ROWS);
   localparam int CW    = $clog2(MAX_COLS);
   localparam int VAW   = RW + CW;
   localparam int CELLS = MAX_ROWS * MAX_COLS;
   localparam int DW    = $clog2(CELLS + 1);
   localparam int STW   = $clog2(CELLS);
   localparam int RLW   = $clog2(MAX_ROWS + 1);
   localparam int CLW   = $clog2(MAX_COLS + 1);
   localparam int CNW   = $clog2(DW);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_NB     = 4'd1;
   localparam logic [3:0] S_CARVE  = 4'd2;
   localparam logic [3:0] S_POP    = 4'd3;
   localparam logic [3:0] S_DIV    = 4'd4;
   localparam logic [3:0] S_LOOP   = 4'd5;
   localparam logic [3:0] S_EMIT0  = 4'd6;
   localparam logic [3:0] S_CLR    = 4'd7;
   localparam logic [3:0] S_RSTOUT = 4'd8;

   // configuration
   logic [6:0]  rows_cfg_ff, rows_cfg_in;
   logic [6:0]  cols_cfg_ff, cols_cfg_in;
   logic [5:0]  srow_cfg_ff, srow_cfg_in;
   logic [5:0]  scol_cfg_ff, scol_cfg_in;
   logic        loops_cfg_ff, loops_cfg_in;
   logic [16:0] thr_cfg_ff, thr_cfg_in;

   // control
   logic [3:0]     state_ff, state_in;
   logic [1:0]     phase_ff, phase_in;
   logic [DW-1:0]  depth_ff, depth_in;
   logic [DW-1:0]  scan_ff, scan_in;
   logic           restart_ff, restart_in;
   logic [VAW-1:0] clr_ff, clr_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // payload
   logic [VAW-1:0] top_ff, top_in;
   logic [VAW-1:0] start_ff, start_in;
   logic [31:0]    rnd_ff, rnd_in;
   logic           up_ff, up_in;
   logic           dn_ff, dn_in;
   logic [1:0]     mod3_ff, mod3_in;
   logic [DW-1:0]  quo_ff, quo_in;
   logic [CLW-1:0] rem_ff, rem_in;
   logic [CNW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]  total_ff, total_in;
   logic           rsp_cv_ff, rsp_cv_in;
   logic [1:0]     rsp_dir_ff, rsp_dir_in;
   logic           rsp_da_ff, rsp_da_in;
   logic [5:0]     rsp_row_ff, rsp_row_in;
   logic [5:0]     rsp_col_ff, rsp_col_in;
   logic [1:0]     rsp_ph_ff, rsp_ph_in;

   // memories
   logic           vis_mem [0:(1 << VAW) - 1];
   logic [VAW-1:0] stk_mem [0:CELLS - 1];
   logic           vis_qa_ff, vis_qb_ff;
   logic [VAW-1:0] stk_q_ff;
   logic           vis_we, vis_wd;
   logic [VAW-1:0] vis_wa, vis_ra, vis_rb;
   logic           stk_we;
   logic [STW-1:0] stk_wa, stk_ra;
   logic [VAW-1:0] stk_wd;

   // combinational helpers
   logic [RLW-1:0] rows_live;
   logic [CLW-1:0] cols_live;
   logic [RW-1:0]  top_r, start_r;
   logic [CW-1:0]  top_c, start_c;
   logic           accept, out_free, emit;
   logic           e_cv, e_da;
   logic [1:0]     e_dir;
   logic [5:0]     e_row, e_col;
   logic [3:0]     cand;
   logic [2:0]     cand_n;
   logic [1:0]     pick_k, pick_dir;
   logic [VAW-1:0] chosen;
   logic [CLW:0]   rem_sh;
   logic           loop_right, loop_down;

   assign top_r = top_ff[VAW-1:CW];
   assign top_c = top_ff[CW-1:0];

   always_comb begin
      if (rows_cfg_ff < 7'd2) begin
         rows_live = RLW'(2);
      end else if (32'(rows_cfg_ff) > MAX_ROWS) begin
         rows_live = RLW'(MAX_ROWS);
      end else begin
         rows_live = RLW'(rows_cfg_ff);
      end
      if (cols_cfg_ff < 7'd2) begin
         cols_live = CLW'(2);
      end else if (32'(cols_cfg_ff) > MAX_COLS) begin
         cols_live = CLW'(MAX_COLS);
      end else begin
         cols_live = CLW'(cols_cfg_ff);
      end
   end

   // start cell clamped into the live grid
   assign start_r = (32'(srow_cfg_ff) < 32'(rows_live)) ? RW'(srow_cfg_ff)
                                                        : RW'(rows_live - RLW'(1));
   assign start_c = (32'(scol_cfg_ff) < 32'(cols_live)) ? CW'(scol_cfg_ff)
                                                        : CW'(cols_live - CLW'(1));

   assign accept   = req_valid && (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // idle reads up/down of the top cell, later states read left/right
   assign vis_ra = (state_ff == S_IDLE) ? {RW'(top_r - RW'(1)), top_c}
                                        : {top_r, CW'(top_c - CW'(1))};
   assign vis_rb = (state_ff == S_IDLE) ? {RW'(top_r + RW'(1)), top_c}
                                        : {top_r, CW'(top_c + CW'(1))};
   assign stk_ra = STW'(depth_ff - DW'(2));

   // neighbour candidates in order up, down, left, right
   assign cand[0] = (top_r != '0) && !up_ff;
   assign cand[1] = ((32'(top_r) + 32'd1) < 32'(rows_live)) && !dn_ff;
   assign cand[2] = (top_c != '0) && !vis_qa_ff;
   assign cand[3] = ((32'(top_c) + 32'd1) < 32'(cols_live)) && !vis_qb_ff;
   assign cand_n  = 3'($countones(cand));

   always_comb begin
      case (cand_n)
         3'd2:    pick_k = {1'b0, rnd_ff[0]};
         3'd3:    pick_k = mod3_ff;
         3'd4:    pick_k = rnd_ff[1:0];
         default: pick_k = 2'd0;
      endcase
   end

   assign pick_dir = gmc_pick(cand, pick_k);

   always_comb begin
      case (pick_dir)
         DIR_UP:    chosen = {RW'(top_r - RW'(1)), top_c};
         DIR_DOWN:  chosen = {RW'(top_r + RW'(1)), top_c};
         DIR_LEFT:  chosen = {top_r, CW'(top_c - CW'(1))};
         DIR_RIGHT: chosen = {top_r, CW'(top_c + CW'(1))};
         default:   chosen = top_ff;
      endcase
   end

   assign rem_sh     = {rem_ff, quo_ff[DW-1]};
   assign loop_right = ((32'(rem_ff) + 32'd1) < 32'(cols_live)) &&
                       ({1'b0, rnd_ff[15:0]} < thr_cfg_ff);
   assign loop_down  = ((32'(quo_ff) + 32'd1) < 32'(rows_live)) &&
                       ({1'b0, rnd_ff[31:16]} < thr_cfg_ff);
   assign start_in   = accept ? {start_r, start_c} : start_ff;

   // configuration writes
   always_comb begin
      rows_cfg_in  = rows_cfg_ff;
      cols_cfg_in  = cols_cfg_ff;
      srow_cfg_in  = srow_cfg_ff;
      scol_cfg_in  = scol_cfg_ff;
      loops_cfg_in = loops_cfg_ff;
      thr_cfg_in   = thr_cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_ROWS:      rows_cfg_in  = csr_wdata[6:0];
            REG_COLS:      cols_cfg_in  = csr_wdata[6:0];
            REG_START_ROW: srow_cfg_in  = csr_wdata[5:0];
            REG_START_COL: scol_cfg_in  = csr_wdata[5:0];
            REG_LOOPS_EN:  loops_cfg_in = csr_wdata[0];
            REG_THRESHOLD: thr_cfg_in   = csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   // main sequencer
   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      depth_in   = depth_ff;
      scan_in    = scan_ff;
      restart_in = restart_ff;
      clr_in     = clr_ff;
      top_in     = top_ff;
      rnd_in     = accept ? req_rnd : rnd_ff;
      up_in      = up_ff;
      dn_in      = dn_ff;
      mod3_in    = mod3_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      cnt_in     = cnt_ff;
      total_in   = total_ff;
      vis_we     = 1'b0;
      vis_wa     = chosen;
      vis_wd     = 1'b1;
      stk_we     = 1'b0;
      stk_wa     = STW'(depth_ff);
      stk_wd     = chosen;
      emit       = 1'b0;
      e_cv       = 1'b0;
      e_dir      = DIR_UP;
      e_da       = 1'b0;
      e_row      = 6'd0;
      e_col      = 6'd0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_restart) begin
                  restart_in = 1'b1;
                  phase_in   = PH_CARVE;
                  depth_in   = DW'(1);
                  scan_in    = '0;
                  clr_in     = '0;
                  state_in   = S_CLR;
               end else begin
                  case (phase_ff)
                     PH_CARVE: begin
                        if (depth_ff == '0) begin
                           phase_in = loops_cfg_ff ? PH_LOOP : PH_DONE;
                           if (loops_cfg_ff) begin
                              scan_in = '0;
                           end
                           state_in = S_EMIT0;
                        end else begin
                           state_in = S_NB;
                        end
                     end
                     PH_LOOP: begin
                        quo_in   = scan_ff;
                        rem_in   = '0;
                        cnt_in   = CNW'(DW - 1);
                        total_in = DW'(rows_live) * DW'(cols_live);
                        state_in = S_DIV;
                     end
                     default: state_in = S_EMIT0;
                  endcase
               end
            end
         end
         S_NB: begin
            up_in    = vis_qa_ff;
            dn_in    = vis_qb_ff;
            mod3_in  = gmc_mod3(rnd_ff);
            state_in = S_CARVE;
         end
         S_CARVE: begin
            if (out_free) begin
               emit  = 1'b1;
               e_row = 6'(top_r);
               e_col = 6'(top_c);
               if (cand_n != 3'd0) begin
                  vis_we = 1'b1;
                  e_cv   = 1'b1;
                  e_dir  = pick_dir;
                  if (depth_ff < DW'(CELLS)) begin
                     stk_we   = 1'b1;
                     depth_in = depth_ff + DW'(1);
                     top_in   = chosen;
                  end
                  state_in = S_IDLE;
               end else begin
                  depth_in = depth_ff - DW'(1);
                  if (depth_ff == DW'(1)) begin
                     phase_in = loops_cfg_ff ? PH_LOOP : PH_DONE;
                     if (loops_cfg_ff) begin
                        scan_in = '0;
                     end
                     state_in = S_IDLE;
                  end else begin
                     state_in = S_POP;
                  end
               end
            end
         end
         S_POP: begin
            top_in   = stk_q_ff;
            state_in = S_IDLE;
         end
         S_DIV: begin
            // restoring divide, one quotient bit a cycle
            if (rem_sh >= {1'b0, cols_live}) begin
               rem_in = CLW'(rem_sh - {1'b0, cols_live});
               quo_in = {quo_ff[DW-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[CLW-1:0];
               quo_in = {quo_ff[DW-2:0], 1'b0};
            end
            if (cnt_ff == '0) begin
               state_in = S_LOOP;
            end else begin
               cnt_in = cnt_ff - CNW'(1);
            end
         end
         S_LOOP: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
               if (scan_ff >= total_ff) begin
                  phase_in = PH_DONE;
               end else begin
                  scan_in = scan_ff + DW'(1);
                  if ((scan_ff + DW'(1)) >= total_ff) begin
                     phase_in = PH_DONE;
                  end
                  e_row = 6'(quo_ff);
                  e_col = 6'(rem_ff);
                  if (loop_right) begin
                     e_cv  = 1'b1;
                     e_dir = DIR_RIGHT;
                     e_da  = loop_down;
                  end else if (loop_down) begin
                     e_cv  = 1'b1;
                     e_dir = DIR_DOWN;
                  end
               end
            end
         end
         S_EMIT0: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_CLR: begin
            vis_we = 1'b1;
            vis_wa = clr_ff;
            vis_wd = 1'b0;
            clr_in = clr_ff + VAW'(1);
            if (clr_ff == {VAW{1'b1}}) begin
               state_in = restart_ff ? S_RSTOUT : S_IDLE;
            end
         end
         S_RSTOUT: begin
            if (out_free) begin
               vis_we     = 1'b1;
               vis_wa     = start_ff;
               stk_we     = 1'b1;
               stk_wa     = '0;
               stk_wd     = start_ff;
               top_in     = start_ff;
               restart_in = 1'b0;
               emit       = 1'b1;
               e_row      = 6'(start_ff[VAW-1:CW]);
               e_col      = 6'(start_ff[CW-1:0]);
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output register
   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      rsp_cv_in  = emit ? e_cv     : rsp_cv_ff;
      rsp_dir_in = emit ? e_dir    : rsp_dir_ff;
      rsp_da_in  = emit ? e_da     : rsp_da_ff;
      rsp_row_in = emit ? e_row    : rsp_row_ff;
      rsp_col_in = emit ? e_col    : rsp_col_ff;
      rsp_ph_in  = emit ? phase_in : rsp_ph_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff  <= ROWS_RESET;
         cols_cfg_ff  <= COLS_RESET;
         srow_cfg_ff  <= '0;
         scol_cfg_ff  <= '0;
         loops_cfg_ff <= 1'b0;
         thr_cfg_ff   <= THRESHOLD_RESET;
         state_ff     <= S_CLR;
         phase_ff     <= PH_IDLE;
         depth_ff     <= '0;
         scan_ff      <= '0;
         restart_ff   <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rows_cfg_ff  <= rows_cfg_in;
         cols_cfg_ff  <= cols_cfg_in;
         srow_cfg_ff  <= srow_cfg_in;
         scol_cfg_ff  <= scol_cfg_in;
         loops_cfg_ff <= loops_cfg_in;
         thr_cfg_ff   <= thr_cfg_in;
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         depth_ff     <= depth_in;
         scan_ff      <= scan_in;
         restart_ff   <= restart_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff     <= top_in;
      start_ff   <= start_in;
      rnd_ff     <= rnd_in;
      up_ff      <= up_in;
      dn_ff      <= dn_in;
      mod3_ff    <= mod3_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      cnt_ff     <= cnt_in;
      total_ff   <= total_in;
      rsp_cv_ff  <= rsp_cv_in;
      rsp_dir_ff <= rsp_dir_in;
      rsp_da_ff  <= rsp_da_in;
      rsp_row_ff <= rsp_row_in;
      rsp_col_ff <= rsp_col_in;
      rsp_ph_ff  <= rsp_ph_in;
   end

   // visited map: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (vis_we) begin
         vis_mem[vis_wa] <= vis_wd;
      end
      vis_qa_ff <= vis_mem[vis_ra];
      vis_qb_ff <= vis_mem[vis_rb];
   end

   // cell stack: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_wa] <= stk_wd;
      end
      stk_q_ff <= stk_mem[stk_ra];
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_carve_valid = rsp_cv_ff;
   assign rsp_carve_dir   = rsp_dir_ff;
   assign rsp_down_also   = rsp_da_ff;
   assign rsp_cell_row    = rsp_row_ff;
   assign rsp_cell_col    = rsp_col_ff;
   assign rsp_phase_now   = rsp_ph_ff;

   `GMC_ASSERT(a_depth_bound, clock, reset, depth_ff <= DW'(CELLS))
   `GMC_ASSERT(a_carve_in_phase, clock, reset, (state_ff == S_CARVE) |-> (phase_ff == PH_CARVE))
   `GMC_ASSERT(a_no_write_on_read, clock, reset, (state_ff == S_NB) |-> !vis_we)
   `GMC_ASSERT(a_pop_has_entry, clock, reset, (state_ff == S_POP) |-> (depth_ff != '0))
   `GMC_ASSERT_NEXT(a_push_depth, clock, reset, stk_we && (state_ff == S_CARVE), depth_ff == $past(depth_ff) + DW'(1))

endmodule
`default_nettype wire
